// ===== rtl/core/packet_link_session_engine_defines.svh =====
// Assertion macros for the packet link session engine.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PACKET_LINK_SESSION_ENGINE_DEFINES_SVH
`define PACKET_LINK_SESSION_ENGINE_DEFINES_SVH

`ifndef SYNTH
// Property must hold at every edge outside reset.
`define PLSE_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define PLSE_ASSERT_NEVER(lbl, clk_s, rstn_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) else $error(msg);
`else
`define PLSE_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define PLSE_ASSERT_NEVER(lbl, clk_s, rstn_s, expr, msg)
`endif

`endif

// ===== rtl/core/plse_pkg.sv =====
// Shared types, codes and constants of the packet link session engine.
// No dependencies; compiled first.
`default_nettype none

package plse_pkg;

  // default sizes and reset values
  localparam int CMD_WORDS_DEF  = 64;
  localparam int RESP_WORDS_DEF = 32;
  localparam logic [23:0] TIMEOUT_RST = 24'd1600000;
  localparam logic [2:0]  MAX_ATT_RST = 3'd3;

  // field widths
  localparam int OP_W    = 3;
  localparam int HDR_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 6;
  localparam int MODE_W  = 2;
  localparam int CNT_W   = 7;
  localparam int TMR_W   = 24;
  localparam int ATT_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [OP_W-1:0] {
    OP_PACKET = 3'd0,
    OP_TICK   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_READ   = 3'd3,
    OP_SEND   = 3'd4
  } op_e_t;

  typedef enum logic [HDR_W-1:0] {
    HDR_CONREQ   = 3'd0,
    HDR_CONACC   = 3'd1,
    HDR_PAYLOAD  = 3'd2,
    HDR_CHECKSUM = 3'd3,
    HDR_ACK      = 3'd4,
    HDR_NACK     = 3'd5,
    HDR_CONREF   = 3'd6
  } hdr_e_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RECV  = 2'd1,
    MODE_READY = 2'd2,
    MODE_AWAIT = 2'd3
  } mode_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT = 1'b0,
    CFG_MAX_ATT = 1'b1
  } cfg_reg_e_t;

  // actions the controller hands to the datapath
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CONNECT,
    ACT_PAYLOAD,
    ACT_CHECK,
    ACT_REFUSE,
    ACT_RESEND,
    ACT_TICK,
    ACT_WRITE,
    ACT_READ,
    ACT_SEND
  } act_e_t;

  // source of a result word
  typedef enum logic [1:0] {
    OSEL_HDR,
    OSEL_CMD,
    OSEL_PAY,
    OSEL_CSUM
  } osel_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_HDR,
    ST_CMD,
    ST_TX,
    ST_CSUM
  } state_e_t;

  typedef struct packed {
    act_e_t  act;
    logic    cap_in;
    logic    out_load;
    osel_e_t out_sel;
    logic    out_last;
    logic    tx_step;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_e_t          mode;
    logic [OP_W-1:0]  op;
    logic [HDR_W-1:0] hdr;
    logic             resp_idx_ok;
    logic             attempts_left;
    logic             tx_stop;
    logic             out_free;
  } dp_stat_t;

  typedef struct packed {
    logic              kind;
    logic [HDR_W-1:0]  send_header;
    logic [BYTE_W-1:0] out_a;
    logic [BYTE_W-1:0] out_b;
    logic [BYTE_W-1:0] out_c;
    logic [BYTE_W-1:0] out_d;
    logic              last;
    logic [MODE_W-1:0] session_mode;
    logic [CNT_W-1:0]  command_words;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/plse_if.sv =====
// Channel interfaces: input words, result words and configuration writes.
// Depends on plse_pkg for field widths.
`default_nettype none

interface plse_in_if;
  import plse_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [HDR_W-1:0]  header;
  logic [BYTE_W-1:0] byte_a;
  logic [BYTE_W-1:0] byte_b;
  logic [BYTE_W-1:0] byte_c;
  logic [BYTE_W-1:0] byte_d;
  logic [IDX_W-1:0]  word_index;

  modport source (output valid, op, header, byte_a, byte_b, byte_c, byte_d, word_index,
                  input ready);
  modport sink   (input valid, op, header, byte_a, byte_b, byte_c, byte_d, word_index,
                  output ready);
endinterface

interface plse_out_if;
  import plse_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [HDR_W-1:0]  send_header;
  logic [BYTE_W-1:0] out_a;
  logic [BYTE_W-1:0] out_b;
  logic [BYTE_W-1:0] out_c;
  logic [BYTE_W-1:0] out_d;
  logic              last;
  logic [MODE_W-1:0] session_mode;
  logic [CNT_W-1:0]  command_words;

  modport source (output valid, kind, send_header, out_a, out_b, out_c, out_d, last,
                         session_mode, command_words,
                  input ready);
  modport sink   (input valid, kind, send_header, out_a, out_b, out_c, out_d, last,
                        session_mode, command_words,
                  output ready);
endinterface

interface plse_cfg_if;
  import plse_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/plse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module plse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output      logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port; read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/plse_ctrl.sv =====
// Controller: decodes each accepted word into an action and sequences results.
// Depends on plse_pkg.
`default_nettype none

module plse_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire plse_pkg::dp_stat_t   stat,
  output      plse_pkg::ctrl_cmd_t  cmd
);
  import plse_pkg::*;

  state_e_t state_r, state_nxt;
  act_e_t   act;

  // action for the captured word in the current mode
  function automatic act_e_t decode(input dp_stat_t s);
    act_e_t a;
    a = ACT_NONE;
    unique case (s.op)
      OP_PACKET: begin
        unique case (s.mode)
          MODE_IDLE:  if (s.hdr == HDR_CONREQ) a = ACT_CONNECT;
          MODE_RECV: begin
            if (s.hdr == HDR_PAYLOAD) a = ACT_PAYLOAD;
            else if (s.hdr == HDR_CHECKSUM) a = ACT_CHECK;
            else a = ACT_REFUSE;
          end
          MODE_AWAIT: begin
            if (s.hdr == HDR_NACK && s.attempts_left) a = ACT_RESEND;
            else a = ACT_REFUSE;
          end
          default: a = ACT_NONE;
        endcase
      end
      OP_TICK:  if (s.mode == MODE_RECV || s.mode == MODE_AWAIT) a = ACT_TICK;
      OP_WRITE: if (s.mode == MODE_READY && s.resp_idx_ok) a = ACT_WRITE;
      OP_READ:  a = ACT_READ;
      OP_SEND:  if (s.mode == MODE_READY) a = ACT_SEND;
      default:  a = ACT_NONE;
    endcase
    return a;
  endfunction

  assign act = decode(stat);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.act = act;
        unique case (act)
          ACT_CONNECT, ACT_CHECK, ACT_REFUSE: state_nxt = ST_HDR;
          ACT_READ:                           state_nxt = ST_CMD;
          ACT_SEND, ACT_RESEND:               state_nxt = ST_TX;
          default:                            state_nxt = ST_IDLE;
        endcase
      end
      ST_HDR: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_HDR;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_CMD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_CMD;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      // one response word per cycle unless stalled; stop after a zero byte or the buffer end
      ST_TX: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_PAY;
          cmd.tx_step  = 1'b1;
          if (stat.tx_stop) state_nxt = ST_CSUM;
        end
      end
      ST_CSUM: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_CSUM;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/plse_dp.sv =====
// Datapath: session registers, lane sums, command and response buffers,
// transmit walker and result register. Depends on plse_pkg and plse_ram.
`default_nettype none

module plse_dp #(
  parameter int CMD_WORDS  = plse_pkg::CMD_WORDS_DEF,
  parameter int RESP_WORDS = plse_pkg::RESP_WORDS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [plse_pkg::OP_W-1:0]        in_op,
  input  wire logic [plse_pkg::HDR_W-1:0]       in_header,
  input  wire logic [4*plse_pkg::BYTE_W-1:0]    in_word,
  input  wire logic [plse_pkg::IDX_W-1:0]       in_word_index,
  input  wire logic                             cfg_we,
  input  wire logic [plse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [plse_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire plse_pkg::ctrl_cmd_t              cmd,
  output      plse_pkg::dp_stat_t               stat,
  input  wire logic                             out_ready,
  output      logic                             out_valid,
  output      plse_pkg::out_item_t              out_item
);
  import plse_pkg::*;

  localparam int CMD_AW  = (CMD_WORDS > 1) ? $clog2(CMD_WORDS) : 1;
  localparam int RESP_AW = (RESP_WORDS > 1) ? $clog2(RESP_WORDS) : 1;

  // captured word
  logic [OP_W-1:0]  op_r;
  logic [HDR_W-1:0] hdr_r;
  logic [3:0][7:0]  word_r;
  logic [IDX_W-1:0] idx_r;

  // session state
  mode_e_t            mode_r, mode_nxt;
  logic [TMR_W-1:0]   timer_r, timer_nxt;
  logic [3:0][7:0]    sums_r, sums_nxt;
  logic [CMD_AW-1:0]  wp_r, wp_nxt;
  logic [CNT_W-1:0]   rc_r, rc_nxt;
  logic [ATT_W-1:0]   att_r, att_nxt;
  logic [TMR_W-1:0]   timeout_r;
  logic [ATT_W-1:0]   max_att_r;
  hdr_e_t             pend_hdr_r, pend_hdr_nxt;
  logic               rd_ok_r;

  // transmit walker
  logic [RESP_AW-1:0] tx_idx_r, tx_idx_nxt;
  logic [3:0][7:0]    cs_r, cs_nxt;

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  // buffers
  logic               resp_re;
  logic [RESP_AW-1:0] resp_raddr;
  logic [3:0][7:0]    resp_rd;
  logic [31:0]        cmd_rd;

  logic cmd_idx_ok, resp_idx_ok, sums_match, has_zero, tx_end, tx_stop, tx_start;

  assign cmd_idx_ok  = {1'b0, idx_r} < CNT_W'(CMD_WORDS);
  assign resp_idx_ok = {1'b0, idx_r} < CNT_W'(RESP_WORDS);
  assign sums_match  = (sums_r == word_r);
  assign has_zero    = (resp_rd[0] == 8'd0) || (resp_rd[1] == 8'd0) ||
                       (resp_rd[2] == 8'd0) || (resp_rd[3] == 8'd0);
  assign tx_end      = (tx_idx_r == RESP_AW'(RESP_WORDS - 1));
  assign tx_stop     = has_zero || tx_end;
  assign tx_start    = (cmd.act == ACT_SEND) || (cmd.act == ACT_RESEND);

  assign resp_re    = tx_start || (cmd.tx_step && !tx_stop);
  assign resp_raddr = tx_start ? '0 : tx_idx_r + RESP_AW'(1);

  plse_ram #(.WIDTH(32), .DEPTH(CMD_WORDS)) u_cmd_ram (
    .clk     (clk),
    .wr_en   (cmd.act == ACT_PAYLOAD),
    .wr_addr (wp_r),
    .wr_data (word_r),
    .rd_en   ((cmd.act == ACT_READ) && cmd_idx_ok),
    .rd_addr (idx_r[CMD_AW-1:0]),
    .rd_data (cmd_rd)
  );

  plse_ram #(.WIDTH(32), .DEPTH(RESP_WORDS)) u_resp_ram (
    .clk     (clk),
    .wr_en   (cmd.act == ACT_WRITE),
    .wr_addr (idx_r[RESP_AW-1:0]),
    .wr_data (word_r),
    .rd_en   (resp_re),
    .rd_addr (resp_raddr),
    .rd_data (resp_rd)
  );

  // session update for the decoded action
  always_comb begin
    mode_nxt     = mode_r;
    timer_nxt    = timer_r;
    sums_nxt     = sums_r;
    wp_nxt       = wp_r;
    rc_nxt       = rc_r;
    att_nxt      = att_r;
    pend_hdr_nxt = pend_hdr_r;
    unique case (cmd.act)
      ACT_CONNECT: begin
        sums_nxt     = '0;
        wp_nxt       = '0;
        rc_nxt       = '0;
        timer_nxt    = '0;
        mode_nxt     = MODE_RECV;
        pend_hdr_nxt = HDR_CONACC;
      end
      ACT_PAYLOAD: begin
        timer_nxt = '0;
        for (int j = 0; j < 4; j++) begin
          sums_nxt[j] = sums_r[j] + word_r[j];
        end
        wp_nxt = (wp_r == CMD_AW'(CMD_WORDS - 1)) ? '0 : wp_r + CMD_AW'(1);
        if (rc_r < CNT_W'(CMD_WORDS)) rc_nxt = rc_r + CNT_W'(1);
      end
      ACT_CHECK: begin
        timer_nxt    = '0;
        mode_nxt     = sums_match ? MODE_READY : MODE_IDLE;
        pend_hdr_nxt = sums_match ? HDR_ACK : HDR_NACK;
      end
      ACT_REFUSE: begin
        timer_nxt    = '0;
        mode_nxt     = MODE_IDLE;
        pend_hdr_nxt = HDR_CONREF;
      end
      ACT_RESEND: begin
        timer_nxt = '0;
        att_nxt   = att_r + ATT_W'(1);
      end
      ACT_TICK: begin
        if (timer_r >= timeout_r) mode_nxt = MODE_IDLE;
        else timer_nxt = timer_r + TMR_W'(1);
      end
      ACT_SEND: begin
        att_nxt   = ATT_W'(1);
        timer_nxt = '0;
        mode_nxt  = MODE_AWAIT;
      end
      default: ;
    endcase
  end

  // transmit walker: running lane sums over the words sent
  always_comb begin
    tx_idx_nxt = tx_idx_r;
    cs_nxt     = cs_r;
    if (tx_start) begin
      tx_idx_nxt = '0;
      cs_nxt     = '0;
    end else if (cmd.tx_step) begin
      for (int j = 0; j < 4; j++) begin
        cs_nxt[j] = cs_r[j] + resp_rd[j];
      end
      if (!tx_stop) tx_idx_nxt = tx_idx_r + RESP_AW'(1);
    end
  end

  // result register
  always_comb begin
    logic [3:0][7:0] w;
    w             = '0;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_item_nxt.kind        = 1'b0;
      out_item_nxt.send_header = HDR_PAYLOAD;
      unique case (cmd.out_sel)
        OSEL_HDR:  out_item_nxt.send_header = pend_hdr_r;
        OSEL_CMD: begin
          out_item_nxt.kind        = 1'b1;
          out_item_nxt.send_header = '0;
          w = rd_ok_r ? cmd_rd : '0;
        end
        OSEL_PAY:  w = resp_rd;
        OSEL_CSUM: begin
          out_item_nxt.send_header = HDR_CHECKSUM;
          w = cs_r;
        end
        default: ;
      endcase
      out_item_nxt.out_a         = w[0];
      out_item_nxt.out_b         = w[1];
      out_item_nxt.out_c         = w[2];
      out_item_nxt.out_d         = w[3];
      out_item_nxt.last          = cmd.out_last;
      out_item_nxt.session_mode  = mode_r;
      out_item_nxt.command_words = rc_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      timer_r     <= '0;
      sums_r      <= '0;
      wp_r        <= '0;
      rc_r        <= '0;
      att_r       <= '0;
      timeout_r   <= TIMEOUT_RST;
      max_att_r   <= MAX_ATT_RST;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      timer_r     <= timer_nxt;
      sums_r      <= sums_nxt;
      wp_r        <= wp_nxt;
      rc_r        <= rc_nxt;
      att_r       <= att_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_e_t'(cfg_index))
          CFG_TIMEOUT: timeout_r <= cfg_data;
          CFG_MAX_ATT: max_att_r <= cfg_data[ATT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      op_r   <= in_op;
      hdr_r  <= in_header;
      word_r <= in_word;
      idx_r  <= in_word_index;
    end
    if (cmd.act == ACT_READ) rd_ok_r <= cmd_idx_ok;
    pend_hdr_r <= pend_hdr_nxt;
    tx_idx_r   <= tx_idx_nxt;
    cs_r       <= cs_nxt;
    out_item_r <= out_item_nxt;
  end

  assign stat.mode          = mode_r;
  assign stat.op            = op_r;
  assign stat.hdr           = hdr_r;
  assign stat.resp_idx_ok   = resp_idx_ok;
  assign stat.attempts_left = (att_r < max_att_r);
  assign stat.tx_stop       = tx_stop;
  assign stat.out_free      = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== rtl/core/packet_link_session_engine.sv =====
// Top level of the packet link session engine: controller plus datapath.
// Depends on plse_pkg, plse_if, plse_ram, plse_ctrl, plse_dp and the defines header.
//
// Usage:
//   in_ch   one word per operation: received packet, tick, host write,
//           host read or send request. Words are taken one at a time.
//   out_ch  result words: packets for the partner (kind 0) or command
//           words returned to the host (kind 1); last marks the final
//           result of an operation.
//   cfg_ch  register writes (0 timeout_ticks, 1 max_attempts), always
//           ready; write only while the engine is idle.
// Timing: an operation without result passes through decode back to idle;
//   one with a single result is decoded, then loads it into the output
//   register once that register is free. A response transmission of n words
//   gives n + 1 result words, checksum last, on consecutive cycles while the
//   output is free, paced by the single read port of the response buffer.
//   The next word is accepted once the last result is in the output
//   register, while that result still waits to be taken.
// Reset: synchronous, active low; session idle, registers at defaults.
//   The buffers are not cleared, so there is no start-up sweep.
// Stall: a held result freezes the sequencer; nothing is dropped.
`default_nettype none

`include "packet_link_session_engine_defines.svh"

module packet_link_session_engine #(
  parameter int CMD_WORDS  = plse_pkg::CMD_WORDS_DEF,
  parameter int RESP_WORDS = plse_pkg::RESP_WORDS_DEF
) (
  input wire logic     clk,
  input wire logic     rst_n,
  plse_in_if.sink      in_ch,
  plse_out_if.source   out_ch,
  plse_cfg_if.sink     cfg_ch
);
  import plse_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  out_item_t out_item;
  logic      out_valid;
  logic      in_ready;

  plse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  plse_dp #(
    .CMD_WORDS  (CMD_WORDS),
    .RESP_WORDS (RESP_WORDS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_op         (in_ch.op),
    .in_header     (in_ch.header),
    .in_word       ({in_ch.byte_d, in_ch.byte_c, in_ch.byte_b, in_ch.byte_a}),
    .in_word_index (in_ch.word_index),
    .cfg_we        (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_ch.ready),
    .out_valid     (out_valid),
    .out_item      (out_item)
  );

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_valid;
  assign out_ch.kind          = out_item.kind;
  assign out_ch.send_header   = out_item.send_header;
  assign out_ch.out_a         = out_item.out_a;
  assign out_ch.out_b         = out_item.out_b;
  assign out_ch.out_c         = out_item.out_c;
  assign out_ch.out_d         = out_item.out_d;
  assign out_ch.last          = out_item.last;
  assign out_ch.session_mode  = out_item.session_mode;
  assign out_ch.command_words = out_item.command_words;

  // checks
  `PLSE_ASSERT(a_load_free, clk, rst_n, cmd.out_load |-> stat.out_free, "result overwritten")
  `PLSE_ASSERT(a_one_item, clk, rst_n, (in_ch.valid && in_ready) |=> !in_ready, "second word taken")
  `PLSE_ASSERT(a_act_after_take, clk, rst_n, (cmd.act != ACT_NONE) |-> $past(in_ch.valid && in_ready), "action without word")
  `PLSE_ASSERT_NEVER(a_count_range, clk, rst_n, out_valid && (out_item.command_words > CNT_W'(CMD_WORDS)), "count too large")

endmodule

`default_nettype wire
